// ===== src/lsc_pkg.sv =====
// Shared constants and types for the line sensor calibration block.
`timescale 1ns / 1ps

package lsc_pkg;

   localparam int CFG_BITS       = 10;
   localparam int CSR_INDEX_BITS = 3;
   localparam int MAX_CHANNELS   = 8;
   localparam int COUNT_BITS     = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_WHITE     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_BLACK     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_SPAN        = 3'd3;

   localparam logic [CFG_BITS-1:0] RESET_START_WHITE     = 10'd1023;
   localparam logic [CFG_BITS-1:0] RESET_START_THRESHOLD = 10'd512;
   localparam logic [CFG_BITS-1:0] RESET_START_BLACK     = 10'd0;
   localparam logic [CFG_BITS-1:0] RESET_MIN_SPAN        = 10'd200;

   localparam logic ACTION_LOAD = 1'b1;

   typedef struct packed {
      logic line_bit;
      logic calibrated;
   } chan_status_type;

endpackage

// ===== src/line_sensor_calibration.sv =====
// Top level of the line sensor calibration block.
//
//   Channel  Direction  Handshake              Payload
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//   req      in         req_valid/req_ready    req_action, req_sample_0..7
//   rsp      out        rsp_valid/rsp_ready    rsp_line_bits, rsp_calibrated_count,
//                                              rsp_all_calibrated
//
// One transaction per cycle while rsp_ready lets results drain; each request passes
// from the input register through the channel logic into the rsp result register.
// Reset sets the configuration and valid registers and channel levels to reset values.
// While rsp_ready is low a pending result holds and req_ready drops once the input
// register is also full. Configuration writes are always taken.
`timescale 1ns / 1ps

module line_sensor_calibration #(
   parameter int CHANNELS    = 8,
   parameter int SAMPLE_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lsc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lsc_pkg::CFG_BITS-1:0]        csr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic [SAMPLE_BITS-1:0]              req_sample_0,
   input  logic [SAMPLE_BITS-1:0]              req_sample_1,
   input  logic [SAMPLE_BITS-1:0]              req_sample_2,
   input  logic [SAMPLE_BITS-1:0]              req_sample_3,
   input  logic [SAMPLE_BITS-1:0]              req_sample_4,
   input  logic [SAMPLE_BITS-1:0]              req_sample_5,
   input  logic [SAMPLE_BITS-1:0]              req_sample_6,
   input  logic [SAMPLE_BITS-1:0]              req_sample_7,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lsc_pkg::MAX_CHANNELS-1:0]    rsp_line_bits,
   output logic [lsc_pkg::COUNT_BITS-1:0]      rsp_calibrated_count,
   output logic                                rsp_all_calibrated
);

   logic [lsc_pkg::CFG_BITS-1:0] start_white_ff;
   logic [lsc_pkg::CFG_BITS-1:0] start_threshold_ff;
   logic [lsc_pkg::CFG_BITS-1:0] start_black_ff;
   logic [lsc_pkg::CFG_BITS-1:0] min_span_ff;

   logic [SAMPLE_BITS-1:0] sample_port[lsc_pkg::MAX_CHANNELS];
   logic [SAMPLE_BITS-1:0] stage_sample_ff[CHANNELS];
   logic                   stage_action_ff;
   logic                   stage_valid_ff;

   logic                               rsp_valid_ff;
   logic [lsc_pkg::MAX_CHANNELS-1:0]   rsp_line_bits_ff;
   logic [lsc_pkg::COUNT_BITS-1:0]     rsp_count_ff;
   logic                               rsp_all_ff;

   logic                               out_free;
   logic                               stage_fire;
   logic                               load_fire;
   logic                               update_fire;
   lsc_pkg::chan_status_type           chan_status[CHANNELS];
   logic [lsc_pkg::MAX_CHANNELS-1:0]   line_bits_in;
   logic [lsc_pkg::COUNT_BITS-1:0]     count_in;
   logic                               all_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_white_ff     <= lsc_pkg::RESET_START_WHITE;
         start_threshold_ff <= lsc_pkg::RESET_START_THRESHOLD;
         start_black_ff     <= lsc_pkg::RESET_START_BLACK;
         min_span_ff        <= lsc_pkg::RESET_MIN_SPAN;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lsc_pkg::CSR_START_WHITE: begin
               start_white_ff <= csr_data;
            end
            lsc_pkg::CSR_START_THRESHOLD: begin
               start_threshold_ff <= csr_data;
            end
            lsc_pkg::CSR_START_BLACK: begin
               start_black_ff <= csr_data;
            end
            lsc_pkg::CSR_MIN_SPAN: begin
               min_span_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   assign sample_port[0] = req_sample_0;
   assign sample_port[1] = req_sample_1;
   assign sample_port[2] = req_sample_2;
   assign sample_port[3] = req_sample_3;
   assign sample_port[4] = req_sample_4;
   assign sample_port[5] = req_sample_5;
   assign sample_port[6] = req_sample_6;
   assign sample_port[7] = req_sample_7;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign stage_fire  = stage_valid_ff && out_free;
   assign load_fire   = stage_fire && (stage_action_ff == lsc_pkg::ACTION_LOAD);
   assign update_fire = stage_fire && (stage_action_ff != lsc_pkg::ACTION_LOAD);
   assign req_ready   = !stage_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_ready) begin
         stage_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_action_ff <= req_action;
         for (int i = 0; i < CHANNELS; i++) begin
            stage_sample_ff[i] <= sample_port[i];
         end
      end
   end

   for (genvar g = 0; g < CHANNELS; g++) begin : gen_channel
      lsc_channel #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_channel (
         .clock           (clock),
         .reset           (reset),
         .update          (update_fire),
         .load            (load_fire),
         .sample          (stage_sample_ff[g]),
         .start_white     (SAMPLE_BITS'(start_white_ff)),
         .start_threshold (SAMPLE_BITS'(start_threshold_ff)),
         .start_black     (SAMPLE_BITS'(start_black_ff)),
         .min_span        (min_span_ff),
         .status          (chan_status[g])
      );
   end

   always_comb begin
      line_bits_in = '0;
      count_in     = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         line_bits_in[i] = chan_status[i].line_bit;
         count_in        = count_in + lsc_pkg::COUNT_BITS'(chan_status[i].calibrated);
      end
      all_in = (count_in == lsc_pkg::COUNT_BITS'(CHANNELS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_fire) begin
         if (stage_action_ff == lsc_pkg::ACTION_LOAD) begin
            rsp_line_bits_ff <= '0;
            rsp_count_ff     <= '0;
            rsp_all_ff       <= 1'b0;
         end else begin
            rsp_line_bits_ff <= line_bits_in;
            rsp_count_ff     <= count_in;
            rsp_all_ff       <= all_in;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_line_bits        = rsp_line_bits_ff;
   assign rsp_calibrated_count = rsp_count_ff;
   assign rsp_all_calibrated   = rsp_all_ff;

   a_load_result_zero: assert property (@(posedge clock) disable iff (reset)
      load_fire |=> rsp_valid && rsp_line_bits == '0 && rsp_calibrated_count == '0
                    && !rsp_all_calibrated)
      else $error("load transaction gave a nonzero result");

   a_all_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_all_calibrated ==
                    (rsp_calibrated_count == lsc_pkg::COUNT_BITS'(CHANNELS)))
      else $error("all_calibrated disagrees with the calibrated count");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_calibrated_count <= lsc_pkg::COUNT_BITS'(CHANNELS))
      else $error("calibrated count exceeds the channel count");

   a_unused_bits_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_line_bits >> CHANNELS) == '0)
      else $error("line bit set for a channel that is not present");

   a_stage_drains: assert property (@(posedge clock) disable iff (reset)
      stage_fire |=> rsp_valid)
      else $error("staged transaction did not reach the result register");

endmodule

// ===== src/lsc_channel.sv =====
// One sensor channel: white, black and threshold tracking with its line bit.
`timescale 1ns / 1ps

module lsc_channel #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          update,
   input  logic                          load,
   input  logic [SAMPLE_BITS-1:0]        sample,
   input  logic [SAMPLE_BITS-1:0]        start_white,
   input  logic [SAMPLE_BITS-1:0]        start_threshold,
   input  logic [SAMPLE_BITS-1:0]        start_black,
   input  logic [lsc_pkg::CFG_BITS-1:0]  min_span,
   output lsc_pkg::chan_status_type      status
);

   localparam int CMP_BITS = (SAMPLE_BITS > lsc_pkg::CFG_BITS) ? SAMPLE_BITS : lsc_pkg::CFG_BITS;

   logic [SAMPLE_BITS-1:0] white_ff;
   logic [SAMPLE_BITS-1:0] black_ff;
   logic [SAMPLE_BITS-1:0] threshold_ff;
   logic [SAMPLE_BITS-1:0] white_in;
   logic [SAMPLE_BITS-1:0] black_in;
   logic [SAMPLE_BITS-1:0] threshold_in;
   logic [SAMPLE_BITS-1:0] span;
   logic [SAMPLE_BITS:0]   level_sum;
   logic                   calibrated;

   always_comb begin
      white_in   = (sample < white_ff) ? sample : white_ff;
      black_in   = (sample > black_ff) ? sample : black_ff;
      span       = black_in - white_in;
      calibrated = (black_in > white_in) && (CMP_BITS'(span) > CMP_BITS'(min_span));
      level_sum  = {1'b0, black_in} + {1'b0, white_in};
      threshold_in = calibrated ? level_sum[SAMPLE_BITS:1] : threshold_ff;
      status.calibrated = calibrated;
      status.line_bit   = sample > threshold_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         white_ff     <= SAMPLE_BITS'(lsc_pkg::RESET_START_WHITE);
         black_ff     <= SAMPLE_BITS'(lsc_pkg::RESET_START_BLACK);
         threshold_ff <= SAMPLE_BITS'(lsc_pkg::RESET_START_THRESHOLD);
      end else if (load) begin
         white_ff     <= start_white;
         black_ff     <= start_black;
         threshold_ff <= start_threshold;
      end else if (update) begin
         white_ff     <= white_in;
         black_ff     <= black_in;
         threshold_ff <= threshold_in;
      end
   end

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the line sensor calibration block.
`timescale 1ns / 1ps

module testbench;

   localparam int CHANNELS       = 8;
   localparam int SAMPLE_BITS    = 10;
   localparam int PHASE_ITEMS    = 250;
   localparam int NUM_PHASES     = 5;
   localparam int NUM_DIRECTED   = 17;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_AT_RESULT = 700;
   localparam int HOLD_CYCLES    = 80;

   localparam logic ACTION_CALIBRATE = 1'b0;
   localparam logic [lsc_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd5;

   typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] sample_set_type;

   typedef struct packed {
      logic [lsc_pkg::MAX_CHANNELS-1:0] line_bits;
      logic [lsc_pkg::COUNT_BITS-1:0]   calibrated_count;
      logic                             all_calibrated;
   } calib_result_type;

   typedef struct packed {
      logic             action;
      sample_set_type   samples;
      logic             typed;
      calib_result_type result;
   } stim_row_type;

   typedef struct packed {
      logic [lsc_pkg::CFG_BITS-1:0] white;
      logic [lsc_pkg::CFG_BITS-1:0] threshold;
      logic [lsc_pkg::CFG_BITS-1:0] black;
      logic [lsc_pkg::CFG_BITS-1:0] span;
      logic                         poke_unused;
   } cal_setting_type;

   // Samples are listed from channel 7 down to channel 0.
   localparam stim_row_type DIRECTED [NUM_DIRECTED] = '{
      '{ACTION_CALIBRATE, {8{10'd0}},    1'b1, '{8'h00, 4'd0, 1'b0}},
      '{ACTION_CALIBRATE, {8{10'd1023}}, 1'b1, '{8'hFF, 4'd8, 1'b1}},
      '{lsc_pkg::ACTION_LOAD, {8{10'd1023}}, 1'b1, '{8'h00, 4'd0, 1'b0}},
      '{ACTION_CALIBRATE, {8{10'd512}},  1'b1, '{8'h00, 4'd0, 1'b0}},
      '{ACTION_CALIBRATE, {8{10'd513}},  1'b1, '{8'hFF, 4'd0, 1'b0}},
      '{lsc_pkg::ACTION_LOAD, {8{10'd0}},    1'b1, '{8'h00, 4'd0, 1'b0}},
      '{ACTION_CALIBRATE, {8{10'd100}},  1'b1, '{8'h00, 4'd0, 1'b0}},
      '{ACTION_CALIBRATE, {10'd1023, 10'd0, 10'd700, 10'd99, 10'd512, 10'd1023,
                           10'd301, 10'd300}, 1'b0, '0},
      '{ACTION_CALIBRATE, {10'd0, 10'd1023, 10'd5, 10'd600, 10'd250, 10'd800,
                           10'd1, 10'd1022}, 1'b0, '0},
      '{ACTION_CALIBRATE, {4{10'h2AA, 10'h155}}, 1'b0, '0},
      '{ACTION_CALIBRATE, {4{10'h155, 10'h2AA}}, 1'b0, '0},
      '{lsc_pkg::ACTION_LOAD, {4{10'h155, 10'h2AA}}, 1'b1, '{8'h00, 4'd0, 1'b0}},
      '{ACTION_CALIBRATE, {8{10'd1023}}, 1'b1, '{8'hFF, 4'd0, 1'b0}},
      '{ACTION_CALIBRATE, {8{10'd0}},    1'b1, '{8'h00, 4'd8, 1'b1}},
      '{ACTION_CALIBRATE, {4{10'd1023, 10'd0}}, 1'b1, '{8'hAA, 4'd8, 1'b1}},
      '{ACTION_CALIBRATE, {8{10'd511}},  1'b1, '{8'h00, 4'd8, 1'b1}},
      '{ACTION_CALIBRATE, {8{10'd512}},  1'b1, '{8'hFF, 4'd8, 1'b1}}
   };

   localparam cal_setting_type SETTINGS_LIST [NUM_PHASES] = '{
      '{10'd1023, 10'd512,  10'd0,    10'd200,  1'b0},
      '{10'd0,    10'd0,    10'd1023, 10'd0,    1'b1},
      '{10'd1023, 10'd1023, 10'd0,    10'd1023, 1'b0},
      '{10'd600,  10'd300,  10'd400,  10'd50,   1'b0},
      '{10'd512,  10'd0,    10'd511,  10'd1022, 1'b0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [lsc_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [lsc_pkg::CFG_BITS-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_action = 1'b0;
   logic [SAMPLE_BITS-1:0] req_sample_0 = '0;
   logic [SAMPLE_BITS-1:0] req_sample_1 = '0;
   logic [SAMPLE_BITS-1:0] req_sample_2 = '0;
   logic [SAMPLE_BITS-1:0] req_sample_3 = '0;
   logic [SAMPLE_BITS-1:0] req_sample_4 = '0;
   logic [SAMPLE_BITS-1:0] req_sample_5 = '0;
   logic [SAMPLE_BITS-1:0] req_sample_6 = '0;
   logic [SAMPLE_BITS-1:0] req_sample_7 = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [lsc_pkg::MAX_CHANNELS-1:0] rsp_line_bits;
   logic [lsc_pkg::COUNT_BITS-1:0] rsp_calibrated_count;
   logic rsp_all_calibrated;

   logic [lsc_pkg::CFG_BITS-1:0] cfg_start_white     = lsc_pkg::RESET_START_WHITE;
   logic [lsc_pkg::CFG_BITS-1:0] cfg_start_threshold = lsc_pkg::RESET_START_THRESHOLD;
   logic [lsc_pkg::CFG_BITS-1:0] cfg_start_black     = lsc_pkg::RESET_START_BLACK;
   logic [lsc_pkg::CFG_BITS-1:0] cfg_min_span        = lsc_pkg::RESET_MIN_SPAN;

   logic [SAMPLE_BITS-1:0] white_level     [CHANNELS];
   logic [SAMPLE_BITS-1:0] black_level     [CHANNELS];
   logic [SAMPLE_BITS-1:0] threshold_level [CHANNELS];

   calib_result_type pending_results [$];
   int mismatches = 0;
   int result_count = 0;
   int stall_left = 0;
   bit hold_done = 1'b0;
   bit steady = 1'b0;
   int quiet_cycles = 0;

   line_sensor_calibration #(
      .CHANNELS(CHANNELS),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_sample_0(req_sample_0),
      .req_sample_1(req_sample_1),
      .req_sample_2(req_sample_2),
      .req_sample_3(req_sample_3),
      .req_sample_4(req_sample_4),
      .req_sample_5(req_sample_5),
      .req_sample_6(req_sample_6),
      .req_sample_7(req_sample_7),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_line_bits(rsp_line_bits),
      .rsp_calibrated_count(rsp_calibrated_count),
      .rsp_all_calibrated(rsp_all_calibrated)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void load_levels(input logic [lsc_pkg::CFG_BITS-1:0] white,
                                       input logic [lsc_pkg::CFG_BITS-1:0] threshold,
                                       input logic [lsc_pkg::CFG_BITS-1:0] black);
      for (int ch = 0; ch < CHANNELS; ch++) begin
         white_level[ch] = white;
         threshold_level[ch] = threshold;
         black_level[ch] = black;
      end
   endfunction

   function automatic calib_result_type calibrate(input logic action,
                                                  input sample_set_type samples);
      calib_result_type result;
      int span;
      logic [SAMPLE_BITS:0] level_sum;
      result = '0;
      if (action == lsc_pkg::ACTION_LOAD) begin
         load_levels(cfg_start_white, cfg_start_threshold, cfg_start_black);
         return result;
      end
      for (int ch = 0; ch < CHANNELS; ch++) begin
         if (samples[ch] < white_level[ch]) white_level[ch] = samples[ch];
         if (samples[ch] > black_level[ch]) black_level[ch] = samples[ch];
         span = int'(black_level[ch]) - int'(white_level[ch]);
         if (span > int'(cfg_min_span)) begin
            result.calibrated_count = result.calibrated_count + 1'b1;
            level_sum = {1'b0, black_level[ch]} + {1'b0, white_level[ch]};
            threshold_level[ch] = level_sum[SAMPLE_BITS:1];
         end
         if (samples[ch] > threshold_level[ch]) result.line_bits[ch] = 1'b1;
      end
      result.all_calibrated = (result.calibrated_count == CHANNELS);
      return result;
   endfunction

   function automatic void apply_csr(input logic [lsc_pkg::CSR_INDEX_BITS-1:0] index,
                                     input logic [lsc_pkg::CFG_BITS-1:0] data);
      case (index)
         lsc_pkg::CSR_START_WHITE: begin
            cfg_start_white = data;
         end
         lsc_pkg::CSR_START_THRESHOLD: begin
            cfg_start_threshold = data;
         end
         lsc_pkg::CSR_START_BLACK: begin
            cfg_start_black = data;
         end
         lsc_pkg::CSR_MIN_SPAN: begin
            cfg_min_span = data;
         end
         default: begin
         end
      endcase
   endfunction

   function automatic sample_set_type random_samples();
      sample_set_type samples;
      int mode;
      int center;
      int spread;
      int value;
      mode = $urandom_range(3);
      center = $urandom_range(1023);
      spread = $urandom_range(150);
      for (int ch = 0; ch < CHANNELS; ch++) begin
         case (mode)
            0: begin
               value = $urandom_range(1023);
            end
            1: begin
               value = $urandom_range(1) ? 1023 : 0;
            end
            default: begin
               value = center + $urandom_range(2 * spread) - spread;
               if (value < 0) value = 0;
               if (value > 1023) value = 1023;
            end
         endcase
         samples[ch] = value[SAMPLE_BITS-1:0];
      end
      return samples;
   endfunction

   task automatic send_item(input logic action, input sample_set_type samples,
                            input logic typed, input calib_result_type typed_result);
      calib_result_type predicted;
      while (!steady && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_sample_0 <= samples[0];
      req_sample_1 <= samples[1];
      req_sample_2 <= samples[2];
      req_sample_3 <= samples[3];
      req_sample_4 <= samples[4];
      req_sample_5 <= samples[5];
      req_sample_6 <= samples[6];
      req_sample_7 <= samples[7];
      do @(posedge clock); while (!req_ready);
      predicted = calibrate(action, samples);
      pending_results.push_back(typed ? typed_result : predicted);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input cal_setting_type setting);
      logic [lsc_pkg::CSR_INDEX_BITS-1:0] indexes [5];
      logic [lsc_pkg::CFG_BITS-1:0] values [5];
      int count;
      indexes = '{lsc_pkg::CSR_START_WHITE, lsc_pkg::CSR_START_THRESHOLD,
                  lsc_pkg::CSR_START_BLACK, lsc_pkg::CSR_MIN_SPAN, CSR_UNUSED};
      values = '{setting.white, setting.threshold, setting.black, setting.span, 10'h3FF};
      count = setting.poke_unused ? 5 : 4;
      for (int i = 0; i < count; i++) begin
         csr_valid <= 1'b1;
         csr_index <= indexes[i];
         csr_data <= values[i];
         do @(posedge clock); while (!csr_ready);
         apply_csr(indexes[i], values[i]);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      load_levels(lsc_pkg::RESET_START_WHITE, lsc_pkg::RESET_START_THRESHOLD,
                  lsc_pkg::RESET_START_BLACK);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      for (int row = 0; row < NUM_DIRECTED; row++) begin
         send_item(DIRECTED[row].action, DIRECTED[row].samples, DIRECTED[row].typed,
                   DIRECTED[row].result);
      end
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         drain();
         configure(SETTINGS_LIST[phase]);
         send_item(lsc_pkg::ACTION_LOAD, random_samples(), 1'b0, '0);
         for (int n = 1; n < PHASE_ITEMS; n++) begin
            steady = (phase == 2 && n < 150);
            if ($urandom_range(99) < 4) begin
               send_item(lsc_pkg::ACTION_LOAD, random_samples(), 1'b0, '0);
            end else begin
               send_item(ACTION_CALIBRATE, random_samples(), 1'b0, '0);
            end
         end
         steady = 1'b0;
      end
      drain();
      if (mismatches == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   always @(posedge clock) begin
      calib_result_type expected;
      if (rsp_valid && rsp_ready) begin
         result_count = result_count + 1;
         if (pending_results.size() == 0) begin
            $error("unexpected result transaction: line_bits %h count %0d all %0d",
                   rsp_line_bits, rsp_calibrated_count, rsp_all_calibrated);
            mismatches = mismatches + 1;
         end else begin
            expected = pending_results.pop_front();
            if (rsp_line_bits !== expected.line_bits) begin
               $error("line_bits: expected %h, actual %h", expected.line_bits, rsp_line_bits);
               mismatches = mismatches + 1;
            end
            if (rsp_calibrated_count !== expected.calibrated_count) begin
               $error("calibrated_count: expected %0d, actual %0d",
                      expected.calibrated_count, rsp_calibrated_count);
               mismatches = mismatches + 1;
            end
            if (rsp_all_calibrated !== expected.all_calibrated) begin
               $error("all_calibrated: expected %0d, actual %0d",
                      expected.all_calibrated, rsp_all_calibrated);
               mismatches = mismatches + 1;
            end
         end
      end
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && result_count >= HOLD_AT_RESULT) begin
         hold_done = 1'b1;
         stall_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady ? 1'b1 : ($urandom_range(99) >= 28);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
